// File: rtl/conv3_pkg.sv
// shared types, register indexes and kernel constants for the 3x3 convolution block
package conv3_pkg;

    typedef logic [7:0] pixel_t;

    // window indexed [row][column]: row 0 top, column 0 left
    typedef pixel_t [2:0][2:0] window_t;

    localparam int POS_W = 10;

    typedef enum logic [2:0] {
        MODE_BOX,
        MODE_GAUSS,
        MODE_PREWITT_X,
        MODE_PREWITT_Y,
        MODE_SOBEL_X,
        MODE_SOBEL_Y,
        MODE_LAPLACE,
        MODE_LAPLACE_DC
    } mode_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_FILTER_MODE
    } cfg_reg_t;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;

    // position info of the pixel entering the window
    typedef struct packed {
        logic               produce;
        logic               last;
        logic [POS_W-1:0]   centre_col;
        logic [POS_W-1:0]   centre_row;
    } pos_t;

    // box: sum * 0.11111 truncated, done as sum * ceil(0.11111 * 2^28) >> 28
    localparam int BOX_SHIFT = 28;
    localparam longint unsigned BOX_RECIP_L =
        ((64'd11111 << BOX_SHIFT) + 64'd99999) / 64'd100000;
    localparam logic [24:0] BOX_RECIP = 25'(BOX_RECIP_L);

    // divide by three for values below 768: x * 683 >> 11
    localparam int DIV3_SHIFT = 11;
    localparam logic [9:0] DIV3_RECIP = 10'd683;

endpackage

// File: rtl/image_convolution_3x3.sv
// top level: 3x3 convolution filter over a raster pixel stream
//
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid / s_tready  s_tdata[7:0] pixel_in
//  m_*       out   m_tvalid / m_tready  m_tdata pixel_out, centre_col, centre_row;
//                                       m_tlast frame_last
//  cfg_*     in    cfg_wr_en            cfg_addr register index, cfg_wr_data value
//
// one item per clock while the output is not stalled; an accepted pixel passes the
// line store read port and stage one, then the result register
// reset clears counters and valid flags and loads default geometry and mode; line stores and the
// window start undefined and are filled before they are read
// a stalled result holds stage one, which holds s_tready low only while full
// border pixels move through the pipeline but never raise m_tvalid
module image_convolution_3x3 import conv3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel_in
    // filtered output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,    // [7:0] pixel_out, [17:8] centre_col,
                                              // [27:18] centre_row, [31:28] zero
    output logic                  m_tlast     // frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // input side
    logic             accept;
    logic [COL_W-1:0] rd_col;
    pos_t             in_pos;
    mode_t            filter_mode;

    // stage one: pixel waiting for its line store data
    logic             s1_valid_reg, s1_valid_next;
    pixel_t           s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    pos_t             s1_pos_reg;
    logic             advance;
    logic             out_free;

    // line store read data, valid in stage one
    pixel_t           top_rd;
    pixel_t           mid_rd;

    // window columns left of the incoming column, [0] top row
    pixel_t           win_left_reg [3];
    pixel_t           win_mid_reg  [3];
    window_t          win;
    pixel_t           filt_pix;

    // result register
    logic             m_valid_reg, m_valid_next;
    pixel_t           pix_out_reg;
    logic [POS_W-1:0] centre_col_reg;
    logic [POS_W-1:0] centre_row_reg;
    logic             last_reg;

    // handshake: stage one moves on when the result register is free
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    conv3_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .step        (accept),
        .col         (rd_col),
        .pos         (in_pos),
        .filter_mode (filter_mode)
    );

    // upper store takes the old middle value, middle store takes the new pixel
    conv3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .rd_data (top_rd)
    );

    conv3_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (rd_col),
        .rd_data (mid_rd)
    );

    // stage one control
    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // result register control
    always_comb begin
        if (out_free) begin
            m_valid_next = advance && s1_pos_reg.produce;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg <= s_tdata;
            s1_col_reg <= rd_col;
            s1_pos_reg <= in_pos;
        end
    end

    // window shifts by one column per item, border items too
    always_ff @(posedge aclk) begin
        if (advance) begin
            win_left_reg <= win_mid_reg;
            win_mid_reg  <= '{top_rd, mid_rd, s1_pix_reg};
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win_left_reg[r];
            win[r][1] = win_mid_reg[r];
        end
        win[0][2] = top_rd;
        win[1][2] = mid_rd;
        win[2][2] = s1_pix_reg;
    end

    conv3_kernel u_kernel (
        .win       (win),
        .mode      (filter_mode),
        .pixel_out (filt_pix)
    );

    // result payload
    always_ff @(posedge aclk) begin
        if (advance && s1_pos_reg.produce) begin
            pix_out_reg    <= filt_pix;
            centre_col_reg <= s1_pos_reg.centre_col;
            centre_row_reg <= s1_pos_reg.centre_row;
            last_reg       <= s1_pos_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, centre_row_reg, centre_col_reg, pix_out_reg};
    assign m_tlast  = last_reg;

    // an accepted item always lands in stage one
    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted item missing from stage one");

    // an interior item leaving stage one becomes a visible result
    a_interior_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_pos_reg.produce |=> m_valid_reg)
        else $error("interior item produced no result");

    // a border item leaving stage one never shows as a result
    a_border_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !s1_pos_reg.produce |=> !m_valid_reg)
        else $error("border item produced a result");

    // line store write never hits the address read in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && advance |-> rd_col != s1_col_reg)
        else $error("line store read and write collide");

endmodule

// File: rtl/conv3_ram.sv
// generic single-write, single-read RAM with registered read data
module conv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/conv3_geom.sv
// configuration registers and raster position counters
module conv3_geom import conv3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wr_data,
    input  logic                          step,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output pos_t                          pos,
    output mode_t                         filter_mode
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WDW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int HDW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;
    localparam int RST_W = ((640 > MAX_WIDTH) ? MAX_WIDTH : 640) - 1;
    localparam int RST_H = ((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480) - 1;

    logic [CW-1:0] width_last_reg,  width_last_next;
    logic [RW-1:0] height_last_reg, height_last_next;
    mode_t         mode_reg,        mode_next;
    logic [CW-1:0] col_reg,         col_next;
    logic [RW-1:0] row_reg,         row_next;

    logic [WDW-1:0] cfg_w;
    logic [HDW-1:0] cfg_h;
    logic [CW-1:0]  clamp_w_last;
    logic [RW-1:0]  clamp_h_last;
    logic [CW-1:0]  col_m1;
    logic [RW-1:0]  row_m1;
    logic           restart;

    // clamp written geometry to 3..max and keep it as last index
    always_comb begin
        cfg_w = WDW'(cfg_wr_data);
        cfg_h = HDW'(cfg_wr_data);
        if (cfg_w < WDW'(3)) begin
            clamp_w_last = CW'(2);
        end else if (cfg_w > WDW'(MAX_WIDTH)) begin
            clamp_w_last = CW'(MAX_WIDTH - 1);
        end else begin
            clamp_w_last = CW'(cfg_w - WDW'(1));
        end
        if (cfg_h < HDW'(3)) begin
            clamp_h_last = RW'(2);
        end else if (cfg_h > HDW'(MAX_HEIGHT)) begin
            clamp_h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            clamp_h_last = RW'(cfg_h - HDW'(1));
        end
    end

    always_comb begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        mode_next        = mode_reg;
        restart          = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH: begin
                    width_last_next = clamp_w_last;
                    restart         = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_last_next = clamp_h_last;
                    restart          = 1'b1;
                end
                REG_FILTER_MODE: begin
                    mode_next = mode_t'(cfg_wr_data[2:0]);
                end
                default: begin
                end
            endcase
        end

        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (step) begin
            if (col_reg == width_last_reg) begin
                col_next = '0;
                row_next = (row_reg == height_last_reg) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= CW'(RST_W);
            height_last_reg <= RW'(RST_H);
            mode_reg        <= MODE_BOX;
            col_reg         <= '0;
            row_reg         <= '0;
        end else begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            mode_reg        <= mode_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

    assign col_m1 = col_reg - CW'(1);
    assign row_m1 = row_reg - RW'(1);

    always_comb begin
        pos.produce    = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
        pos.last       = (col_reg == width_last_reg) && (row_reg == height_last_reg);
        pos.centre_col = POS_W'(col_m1);
        pos.centre_row = POS_W'(row_m1);
    end

    assign col         = col_reg;
    assign filter_mode = mode_reg;

endmodule

// File: rtl/conv3_kernel.sv
// eight 3x3 kernels with their scaling, one result per window
module conv3_kernel import conv3_pkg::*; (
    input  window_t win,
    input  mode_t   mode,
    output pixel_t  pixel_out
);

    logic signed [12:0] p [3][3];
    logic signed [12:0] left_sum, right_sum, top_sum, bot_sum, mid_sum;
    logic signed [12:0] all_sum, nbr_sum;
    logic signed [12:0] gauss_sum;
    logic signed [12:0] prew_x, prew_y, sob_x, sob_y, lap, lap_dc;
    logic signed [12:0] grad;
    logic [11:0]        mag;
    logic [36:0]        box_prod;
    logic [19:0]        div3_prod;
    pixel_t             lap_dc_clamp;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p[r][c] = $signed({5'b0, win[r][c]});
            end
        end
    end

    always_comb begin
        left_sum  = p[0][0] + p[1][0] + p[2][0];
        right_sum = p[0][2] + p[1][2] + p[2][2];
        top_sum   = p[0][0] + p[0][1] + p[0][2];
        mid_sum   = p[1][0] + p[1][1] + p[1][2];
        bot_sum   = p[2][0] + p[2][1] + p[2][2];
        all_sum   = top_sum + mid_sum + bot_sum;
        nbr_sum   = all_sum - p[1][1];

        gauss_sum = p[0][0] + (p[0][1] <<< 1) + p[0][2]
                  + (p[1][0] <<< 1) + (p[1][1] <<< 2) + (p[1][2] <<< 1)
                  + p[2][0] + (p[2][1] <<< 1) + p[2][2];

        prew_x = right_sum - left_sum;
        prew_y = bot_sum - top_sum;
        sob_x  = (p[0][2] + (p[1][2] <<< 1) + p[2][2])
               - (p[0][0] + (p[1][0] <<< 1) + p[2][0]);
        sob_y  = (p[2][0] + (p[2][1] <<< 1) + p[2][2])
               - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
        lap    = (p[1][1] <<< 3) - nbr_sum;
        lap_dc = (p[1][1] <<< 3) + p[1][1] - nbr_sum;
    end

    // one magnitude path shared by the gradient kernels and the Laplace kernel
    always_comb begin
        case (mode)
            MODE_PREWITT_X: grad = prew_x;
            MODE_PREWITT_Y: grad = prew_y;
            MODE_SOBEL_X:   grad = sob_x;
            MODE_SOBEL_Y:   grad = sob_y;
            MODE_LAPLACE:   grad = lap;
            default:        grad = '0;
        endcase
        mag = grad[12] ? 12'(-grad) : 12'(grad);
    end

    assign box_prod  = 37'(all_sum[11:0]) * 37'(BOX_RECIP);
    assign div3_prod = 20'(mag[9:0]) * 20'(DIV3_RECIP);

    always_comb begin
        if (lap_dc < 13'sd0) begin
            lap_dc_clamp = 8'd0;
        end else if (lap_dc > 13'sd255) begin
            lap_dc_clamp = 8'd255;
        end else begin
            lap_dc_clamp = lap_dc[7:0];
        end
    end

    always_comb begin
        case (mode)
            MODE_BOX:        pixel_out = box_prod[BOX_SHIFT +: 8];
            MODE_GAUSS:      pixel_out = gauss_sum[11:4];
            MODE_PREWITT_X,
            MODE_PREWITT_Y:  pixel_out = div3_prod[DIV3_SHIFT +: 8];
            MODE_SOBEL_X,
            MODE_SOBEL_Y:    pixel_out = mag[9:2];
            MODE_LAPLACE:    pixel_out = mag[10:3];
            MODE_LAPLACE_DC: pixel_out = lap_dc_clamp;
            default:         pixel_out = '0;
        endcase
    end

endmodule
